// ----- hw/rtl/kf1d_pkg.sv -----
// Shared types and constants of the one-dimensional Kalman filter core.
package kf1d_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int DIV_STEPS       = DATA_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SENSOR_VARIANCE  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MOTION_VARIANCE  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INITIAL_MEAN     = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INITIAL_VARIANCE = 8'd3;

   localparam logic [DATA_WIDTH-1:0] SENSOR_VARIANCE_RESET  = 32'h0001_0000;
   localparam logic [DATA_WIDTH-1:0] MOTION_VARIANCE_RESET  = 32'h0001_0000;
   localparam logic [DATA_WIDTH-1:0] INITIAL_MEAN_RESET     = 32'h0000_0000;
   localparam logic [DATA_WIDTH-1:0] INITIAL_VARIANCE_RESET = 32'h0001_0000;

   localparam logic [DATA_WIDTH-1:0] MEAN_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_WIDTH-1:0] MEAN_MIN = 32'h8000_0000;
   localparam logic [DATA_WIDTH-1:0] VAR_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic capture;
      logic prep;
      logic mul_en;
      logic mul_var;
      logic div_load;
      logic div_step;
      logic save_mean;
      logic finish;
   } kf1d_cmd_type;

   typedef struct packed {
      logic denom_zero;
      logic out_free;
   } kf1d_status_type;

endpackage

// ----- hw/rtl/kf1d_ctrl.sv -----
// Sequencer of the filter step: prepare, multiply, divide, finish.
module kf1d_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  kf1d_pkg::kf1d_status_type status,
   output kf1d_pkg::kf1d_cmd_type    cmd
);
   import kf1d_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_MEAN,
      ST_LOAD_MEAN,
      ST_DIV_MEAN,
      ST_MUL_VAR,
      ST_LOAD_VAR,
      ST_DIV_VAR,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       last_step;

   assign last_step = (count_ff == DIV_COUNT_WIDTH'(DIV_STEPS - 1));
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL_MEAN;
         end
         ST_MUL_MEAN: begin
            cmd.mul_en = 1'b1;
            state_in   = status.denom_zero ? ST_FINISH : ST_LOAD_MEAN;
         end
         ST_LOAD_MEAN: begin
            cmd.div_load = 1'b1;
            count_in     = '0;
            state_in     = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (last_step) begin
               state_in = ST_MUL_VAR;
            end
         end
         ST_MUL_VAR: begin
            cmd.save_mean = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_var   = 1'b1;
            state_in      = ST_LOAD_VAR;
         end
         ST_LOAD_VAR: begin
            cmd.div_load = 1'b1;
            count_in     = '0;
            state_in     = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/kf1d_dp.sv -----
// Datapath: registers, estimate, shared multiplier, restoring divider, result word.
module kf1d_dp (
   input  logic                                          clock,
   input  logic                                          reset,
   input  kf1d_pkg::kf1d_cmd_type                        cmd,
   output kf1d_pkg::kf1d_status_type                     status,
   input  logic                                          csr_valid,
   input  logic [kf1d_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [kf1d_pkg::DATA_WIDTH-1:0]               csr_data,
   input  logic signed [kf1d_pkg::DATA_WIDTH-1:0]        req_measured_position,
   input  logic signed [kf1d_pkg::DATA_WIDTH-1:0]        req_motion_offset,
   input  logic                                          req_restart,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic signed [kf1d_pkg::DATA_WIDTH-1:0]        rsp_fused_mean,
   output logic [kf1d_pkg::DATA_WIDTH-1:0]               rsp_fused_variance,
   output logic signed [kf1d_pkg::DATA_WIDTH-1:0]        rsp_predicted_mean,
   output logic [kf1d_pkg::DATA_WIDTH-1:0]               rsp_predicted_variance
);
   import kf1d_pkg::*;

   localparam int W = DATA_WIDTH;

   // configuration
   logic [W-1:0] sensor_var_ff, sensor_var_in;
   logic [W-1:0] motion_var_ff, motion_var_in;
   logic [W-1:0] init_mean_ff, init_mean_in;
   logic [W-1:0] init_var_ff, init_var_in;
   // estimate
   logic [W-1:0] est_mean_ff, est_mean_in;
   logic [W-1:0] est_var_ff, est_var_in;
   // working registers
   logic [W-1:0]          meas_ff, meas_in;
   logic [W-1:0]          offs_ff, offs_in;
   logic [W-1:0]          prior_ff, prior_in;
   logic [W-1:0]          pv_ff, pv_in;
   logic [W:0]            denom_ff, denom_in;
   logic                  neg_ff, neg_in;
   logic [W-1:0]          mag_ff, mag_in;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic [W:0]            rem_ff, rem_in;
   logic [W-1:0]          dvd_ff, dvd_in;
   logic [W-1:0]          fmean_ff, fmean_in;
   // result word
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  out_fmean_ff, out_fmean_in;
   logic [W-1:0]  out_fvar_ff, out_fvar_in;
   logic [W-1:0]  out_pmean_ff, out_pmean_in;
   logic [W-1:0]  out_pvar_ff, out_pvar_in;

   logic [W:0]    diff;
   logic [W:0]    diff_neg;
   logic [W-1:0]  mul_a;
   logic [W+1:0]  trial;
   logic [W+1:0]  trial_sub;
   logic          trial_ge;
   logic [W+1:0]  corr_sum;
   logic [W-1:0]  fused_var;
   logic [W:0]    pmean_sum;
   logic [W-1:0]  pmean_sat;
   logic [W:0]    pvar_sum;
   logic [W-1:0]  pvar_sat;

   assign status.denom_zero = (denom_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign diff     = {meas_ff[W-1], meas_ff} - {prior_ff[W-1], prior_ff};
   assign diff_neg = -diff;
   assign mul_a    = cmd.mul_var ? sensor_var_ff : mag_ff;

   assign trial     = {rem_ff, dvd_ff[W-1]};
   assign trial_ge  = (trial >= {1'b0, denom_ff});
   assign trial_sub = trial - {1'b0, denom_ff};

   assign corr_sum = neg_ff ? ({{2{prior_ff[W-1]}}, prior_ff} - {2'b00, dvd_ff})
                            : ({{2{prior_ff[W-1]}}, prior_ff} + {2'b00, dvd_ff});

   assign fused_var = status.denom_zero ? '0 : dvd_ff;
   assign pmean_sum = {fmean_ff[W-1], fmean_ff} + {offs_ff[W-1], offs_ff};
   assign pmean_sat = (pmean_sum[W] != pmean_sum[W-1])
                      ? (pmean_sum[W] ? MEAN_MIN : MEAN_MAX) : pmean_sum[W-1:0];
   assign pvar_sum  = {1'b0, fused_var} + {1'b0, motion_var_ff};
   assign pvar_sat  = pvar_sum[W] ? VAR_MAX : pvar_sum[W-1:0];

   always_comb begin
      sensor_var_in = sensor_var_ff;
      motion_var_in = motion_var_ff;
      init_mean_in  = init_mean_ff;
      init_var_in   = init_var_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SENSOR_VARIANCE:  sensor_var_in = csr_data;
            REG_MOTION_VARIANCE:  motion_var_in = csr_data;
            REG_INITIAL_MEAN:     init_mean_in  = csr_data;
            REG_INITIAL_VARIANCE: init_var_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      meas_in      = meas_ff;
      offs_in      = offs_ff;
      prior_in     = prior_ff;
      pv_in        = pv_ff;
      denom_in     = denom_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      fmean_in     = fmean_ff;
      est_mean_in  = est_mean_ff;
      est_var_in   = est_var_ff;
      out_fmean_in = out_fmean_ff;
      out_fvar_in  = out_fvar_ff;
      out_pmean_in = out_pmean_ff;
      out_pvar_in  = out_pvar_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.capture) begin
         meas_in  = req_measured_position;
         offs_in  = req_motion_offset;
         prior_in = req_restart ? init_mean_ff : est_mean_ff;
         pv_in    = req_restart ? init_var_ff : est_var_ff;
      end
      if (cmd.prep) begin
         denom_in = {1'b0, pv_ff} + {1'b0, sensor_var_ff};
         neg_in   = diff[W];
         mag_in   = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
         fmean_in = prior_ff;
      end
      if (cmd.mul_en) begin
         prod_in = {{W{1'b0}}, mul_a} * {{W{1'b0}}, pv_ff};
      end
      // quotient fits in W bits, so the upper half starts as the remainder
      if (cmd.div_load) begin
         rem_in = {1'b0, prod_ff[PROD_WIDTH-1:W]};
         dvd_in = prod_ff[W-1:0];
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_sub[W:0] : trial[W:0];
         dvd_in = {dvd_ff[W-2:0], trial_ge};
      end
      if (cmd.save_mean) begin
         fmean_in = corr_sum[W-1:0];
      end
      if (cmd.finish) begin
         est_mean_in  = pmean_sat;
         est_var_in   = pvar_sat;
         out_fmean_in = fmean_ff;
         out_fvar_in  = fused_var;
         out_pmean_in = pmean_sat;
         out_pvar_in  = pvar_sat;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_var_ff <= SENSOR_VARIANCE_RESET;
         motion_var_ff <= MOTION_VARIANCE_RESET;
         init_mean_ff  <= INITIAL_MEAN_RESET;
         init_var_ff   <= INITIAL_VARIANCE_RESET;
         est_mean_ff   <= INITIAL_MEAN_RESET;
         est_var_ff    <= INITIAL_VARIANCE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sensor_var_ff <= sensor_var_in;
         motion_var_ff <= motion_var_in;
         init_mean_ff  <= init_mean_in;
         init_var_ff   <= init_var_in;
         est_mean_ff   <= est_mean_in;
         est_var_ff    <= est_var_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff      <= meas_in;
      offs_ff      <= offs_in;
      prior_ff     <= prior_in;
      pv_ff        <= pv_in;
      denom_ff     <= denom_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      fmean_ff     <= fmean_in;
      out_fmean_ff <= out_fmean_in;
      out_fvar_ff  <= out_fvar_in;
      out_pmean_ff <= out_pmean_in;
      out_pvar_ff  <= out_pvar_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_fused_mean         = out_fmean_ff;
   assign rsp_fused_variance     = out_fvar_ff;
   assign rsp_predicted_mean     = out_pmean_ff;
   assign rsp_predicted_variance = out_pvar_ff;

   // quotient must fit in one word
   a_div_load_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> ({1'b0, prod_ff[PROD_WIDTH-1:W]} < denom_ff))
      else $error("divider upper half not below divisor");

   a_rem_below_denom: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < denom_ff))
      else $error("divider remainder out of range");

   // fused variance never exceeds either input variance
   a_fused_var_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !status.denom_zero) |-> (dvd_ff <= pv_ff && dvd_ff <= sensor_var_ff))
      else $error("fused variance above an input variance");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.finish)
      else $error("result word overwritten while pending");

endmodule

// ----- hw/rtl/kalman_filter_1d_core.sv -----
// Top level of the one-dimensional Kalman filter core.
//
// Request channel (req_*): measured position, motion offset and a restart flag,
// taken with valid/ready. One word is processed at a time; req_ready is high
// while the core is idle.
// Response channel (rsp_*): fused and predicted mean and variance, held in an
// output register until taken. A stalled receiver does not stop the next
// request from being accepted; the core only waits at the end of that request
// until the pending word has been taken.
// Configuration channel (csr_*): index 0 sensor variance, 1 motion variance,
// 2 initial mean, 3 initial variance; other indexes are ignored. Always ready.
// Each request runs two 32-step restoring divisions on one shared divider and one
// shared 32x32 multiplier; both divisions are skipped when the prior and sensor
// variances are both zero. A new request is taken only once the last one is done.
// Reset (synchronous) loads the register defaults (variances 1.0, mean 0)
// into the configuration and the estimate, and clears any pending response.
module kalman_filter_1d_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kf1d_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [kf1d_pkg::DATA_WIDTH-1:0]        csr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [kf1d_pkg::DATA_WIDTH-1:0] req_measured_position,
   input  logic signed [kf1d_pkg::DATA_WIDTH-1:0] req_motion_offset,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [kf1d_pkg::DATA_WIDTH-1:0] rsp_fused_mean,
   output logic [kf1d_pkg::DATA_WIDTH-1:0]        rsp_fused_variance,
   output logic signed [kf1d_pkg::DATA_WIDTH-1:0] rsp_predicted_mean,
   output logic [kf1d_pkg::DATA_WIDTH-1:0]        rsp_predicted_variance
);
   import kf1d_pkg::*;

   kf1d_cmd_type    cmd;
   kf1d_status_type status;

   assign csr_ready = 1'b1;

   kf1d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kf1d_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_measured_position  (req_measured_position),
      .req_motion_offset      (req_motion_offset),
      .req_restart            (req_restart),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_fused_mean         (rsp_fused_mean),
      .rsp_fused_variance     (rsp_fused_variance),
      .rsp_predicted_mean     (rsp_predicted_mean),
      .rsp_predicted_variance (rsp_predicted_variance)
   );

endmodule
